// ----- hdl/first_fit_free_list_allocator_top_macros.svh -----
// assertion macros for the first-fit allocator checker
// no dependencies; included by the checker file only
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication, reset-qualified
`define FFA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, reset-qualified
`define FFA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/ffa_pkg.sv -----
// shared types, codes and constants of the first-fit allocator
// no dependencies; imported by every rtl module
package ffa_pkg;

	localparam int HEAP_BYTES   = 4096;
	localparam int HEADER_BYTES = 16;
	localparam int OFF_W        = 12;
	localparam int SIZE_W       = 12;
	localparam int LINK_W       = OFF_W + 1;
	localparam int HB_W         = 13;
	localparam int STEP_W       = 13;
	localparam int HB_MIN       = 64;

	localparam logic [1:0] OP_ALLOC  = 2'd0;
	localparam logic [1:0] OP_FREE   = 2'd1;
	localparam logic [1:0] OP_RESIZE = 2'd2;
	localparam logic [1:0] OP_INIT   = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NOFIT = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef enum logic [2:0] {
		RES_NONE,
		RES_NULL,
		RES_FAIL,
		RES_RANGE,
		RES_KEEP,
		RES_GRANT
	} ffa_res_t;

	// commands from controller to datapath
	typedef struct packed {
		logic     latch_in;
		logic     init_wr;
		logic     rd_off;
		logic     rd_cur;
		logic     load_walk;
		logic     advance;
		logic     split_nn_wr;
		logic     split_cur_wr;
		logic     unlink_wr;
		logic     free_wr;
		ffa_res_t res;
	} ffa_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic [1:0] op;
		logic       has_address;
		logic       in_range;
		logic       cur_ok;
		logic       walk_done;
		logic       fit;
		logic       split_ok;
		logic       keep;
		logic       out_busy;
	} ffa_stat_t;

endpackage

// ----- hdl/ffa_ctrl.sv -----
// controller state machine of the first-fit allocator
// depends on ffa_pkg; drives the datapath through ffa_cmd_t
module ffa_ctrl import ffa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_tvalid,
	output logic      in_tready,
	input  ffa_stat_t stat,
	output ffa_cmd_t  cmd
);

	typedef enum logic [8:0] {
		S_BOOT   = 9'b000000001,
		S_IDLE   = 9'b000000010,
		S_DECODE = 9'b000000100,
		S_RCHK   = 9'b000001000,
		S_ARD    = 9'b000010000,
		S_ACHK   = 9'b000100000,
		S_SPLIT  = 9'b001000000,
		S_UNLINK = 9'b010000000,
		S_FREE   = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   alloc_like;
	logic   moving;

	assign alloc_like = (stat.op == OP_ALLOC) || ((stat.op == OP_RESIZE) && !stat.has_address);
	assign moving     = (stat.op == OP_RESIZE) && stat.has_address;
	assign in_tready  = (state_q == S_IDLE) && !stat.out_busy;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.res = RES_NONE;
		case (state_q)
			S_BOOT: begin
				cmd.init_wr = 1'b1;
				state_d     = S_IDLE;
			end
			S_IDLE: begin
				if (in_tvalid && in_tready) begin
					cmd.latch_in = 1'b1;
					state_d      = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_IDLE;
				if (alloc_like) begin
					cmd.load_walk = 1'b1;
					state_d       = S_ARD;
				end else if (stat.op == OP_FREE) begin
					if (!stat.has_address) begin
						cmd.res = RES_NULL;
					end else if (!stat.in_range) begin
						cmd.res = RES_RANGE;
					end else begin
						cmd.free_wr = 1'b1;
						cmd.res     = RES_NULL;
					end
				end else if (stat.op == OP_RESIZE) begin
					if (!stat.in_range) begin
						cmd.res = RES_RANGE;
					end else begin
						cmd.rd_off = 1'b1;
						state_d    = S_RCHK;
					end
				end else begin
					cmd.init_wr = 1'b1;
					cmd.res     = RES_NULL;
				end
			end
			S_RCHK: begin
				if (stat.keep) begin
					cmd.res = RES_KEEP;
					state_d = S_IDLE;
				end else begin
					cmd.load_walk = 1'b1;
					state_d       = S_ARD;
				end
			end
			S_ARD: begin
				if (!stat.cur_ok || stat.walk_done) begin
					cmd.res = RES_FAIL;
					state_d = S_IDLE;
				end else begin
					cmd.rd_cur = 1'b1;
					state_d    = S_ACHK;
				end
			end
			S_ACHK: begin
				if (!stat.fit) begin
					cmd.advance = 1'b1;
					state_d     = S_ARD;
				end else if (stat.split_ok) begin
					cmd.split_nn_wr = 1'b1;
					state_d         = S_SPLIT;
				end else begin
					state_d = S_UNLINK;
				end
			end
			S_SPLIT: begin
				cmd.split_cur_wr = 1'b1;
				state_d          = S_UNLINK;
			end
			S_UNLINK: begin
				cmd.unlink_wr = 1'b1;
				if (moving) begin
					state_d = S_FREE;
				end else begin
					cmd.res = RES_GRANT;
					state_d = S_IDLE;
				end
			end
			S_FREE: begin
				cmd.free_wr = 1'b1;
				cmd.res     = RES_GRANT;
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_BOOT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- hdl/ffa_dp.sv -----
// datapath of the first-fit allocator: header stores, walk registers, result register
// depends on ffa_pkg; controlled by ffa_ctrl through ffa_cmd_t
module ffa_dp import ffa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              heap_bytes_we,
	input  logic [HB_W-1:0]   heap_bytes_wdata,
	input  logic [31:0]       in_tdata,
	input  ffa_cmd_t          cmd,
	output ffa_stat_t         stat,
	output logic              out_tvalid,
	input  logic              out_tready,
	output logic [31:0]       out_tdata
);

	// header stores: size and link (valid bit over next offset)
	logic [SIZE_W-1:0] size_mem [HEAP_BYTES];
	logic [LINK_W-1:0] link_mem [HEAP_BYTES];

	logic [HB_W-1:0]   heap_bytes_q;
	logic [1:0]        op_q;
	logic              has_q;
	logic [OFF_W-1:0]  addr_q;
	logic [SIZE_W-1:0] req_q;
	logic [LINK_W-1:0] head_q;
	logic [OFF_W-1:0]  cur_q;
	logic              cur_ok_q;
	logic [OFF_W-1:0]  prev_q;
	logic              prev_ok_q;
	logic [STEP_W-1:0] steps_q;
	logic              split_done_q;
	logic [SIZE_W-1:0] size_rd_q;
	logic [LINK_W-1:0] link_rd_q;
	logic [SIZE_W-1:0] old_q;

	logic              out_tvalid_q;
	logic [1:0]        status_q;
	logic              rvalid_q;
	logic [OFF_W-1:0]  raddr_q;
	logic              cneed_q;
	logic [SIZE_W-1:0] cbytes_q;

	logic [OFF_W-1:0]  off;
	logic [13:0]       nn_wide;
	logic [OFF_W-1:0]  nn;
	logic [HB_W-1:0]   req_plus;
	logic [HB_W-1:0]   rem_wide;
	logic [LINK_W-1:0] eff_link;
	logic [HB_W-1:0]   hb_sat;
	logic [HB_W-1:0]   init_size;

	logic              size_we;
	logic [OFF_W-1:0]  size_wa;
	logic [SIZE_W-1:0] size_wd;
	logic              link_we;
	logic [OFF_W-1:0]  link_wa;
	logic [LINK_W-1:0] link_wd;
	logic [OFF_W-1:0]  rd_addr;

	// derived values
	assign off       = addr_q - OFF_W'(HEADER_BYTES);
	assign nn_wide   = 14'(cur_q) + 14'(HEADER_BYTES) + 14'(req_q);
	assign nn        = nn_wide[OFF_W-1:0];
	assign req_plus  = HB_W'(req_q) + HB_W'(HEADER_BYTES);
	assign rem_wide  = HB_W'(size_rd_q) - req_plus;
	assign eff_link  = split_done_q ? {1'b1, nn} : link_rd_q;
	assign init_size = heap_bytes_q - HB_W'(HEADER_BYTES);

	// saturate the written heap size
	always_comb begin
		hb_sat = heap_bytes_wdata;
		if (heap_bytes_wdata < HB_W'(HB_MIN)) begin
			hb_sat = HB_W'(HB_MIN);
		end else if (heap_bytes_wdata > HB_W'(HEAP_BYTES)) begin
			hb_sat = HB_W'(HEAP_BYTES);
		end
	end

	// status to controller
	always_comb begin
		stat.op          = op_q;
		stat.has_address = has_q;
		stat.in_range    = (addr_q >= OFF_W'(HEADER_BYTES)) && (HB_W'(addr_q) < heap_bytes_q);
		stat.cur_ok      = cur_ok_q;
		stat.walk_done   = (steps_q == STEP_W'(HEAP_BYTES));
		stat.fit         = (size_rd_q >= req_q);
		stat.split_ok    = (HB_W'(size_rd_q) > req_plus) && (nn_wide < 14'(HEAP_BYTES));
		stat.keep        = (size_rd_q >= req_q);
		stat.out_busy    = out_tvalid_q;
	end

	// store write port select
	always_comb begin
		size_we = 1'b0;
		size_wa = '0;
		size_wd = '0;
		link_we = 1'b0;
		link_wa = '0;
		link_wd = '0;
		if (cmd.init_wr) begin
			size_we = 1'b1;
			size_wd = init_size[SIZE_W-1:0];
			link_we = 1'b1;
		end else if (cmd.split_nn_wr) begin
			size_we = 1'b1;
			size_wa = nn;
			size_wd = rem_wide[SIZE_W-1:0];
			link_we = 1'b1;
			link_wa = nn;
			link_wd = link_rd_q;
		end else if (cmd.split_cur_wr) begin
			size_we = 1'b1;
			size_wa = cur_q;
			size_wd = req_q;
			link_we = 1'b1;
			link_wa = cur_q;
			link_wd = {1'b1, nn};
		end else if (cmd.unlink_wr) begin
			link_we = prev_ok_q;
			link_wa = prev_q;
			link_wd = eff_link;
		end else if (cmd.free_wr) begin
			link_we = 1'b1;
			link_wa = off;
			link_wd = head_q;
		end
	end

	assign rd_addr = cmd.rd_off ? off : cur_q;

	// header stores
	always_ff @(posedge clk) begin
		if (size_we) begin
			size_mem[size_wa] <= size_wd;
		end
		if (link_we) begin
			link_mem[link_wa] <= link_wd;
		end
		if (cmd.rd_off || cmd.rd_cur) begin
			size_rd_q <= size_mem[rd_addr];
			link_rd_q <= link_mem[rd_addr];
		end
	end

	// input item, resize payload and walk position registers
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			op_q   <= in_tdata[1:0];
			has_q  <= in_tdata[2];
			addr_q <= in_tdata[14:3];
			req_q  <= in_tdata[26:15];
		end
		if (cmd.rd_off) begin
			old_q <= size_mem[off];
		end
		if (cmd.load_walk) begin
			cur_q <= head_q[OFF_W-1:0];
		end else if (cmd.advance) begin
			prev_q <= cur_q;
			cur_q  <= link_rd_q[OFF_W-1:0];
		end
	end

	// walk control, list head and heap size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_bytes_q <= HB_W'(HEAP_BYTES);
			head_q       <= {1'b1, {OFF_W{1'b0}}};
			cur_ok_q     <= 1'b0;
			prev_ok_q    <= 1'b0;
			steps_q      <= '0;
			split_done_q <= 1'b0;
		end else begin
			if (heap_bytes_we) begin
				heap_bytes_q <= hb_sat;
			end
			if (cmd.init_wr) begin
				head_q <= {1'b1, {OFF_W{1'b0}}};
			end else if (cmd.unlink_wr && !prev_ok_q) begin
				head_q <= eff_link;
			end else if (cmd.free_wr) begin
				head_q <= {1'b1, off};
			end
			if (cmd.load_walk) begin
				cur_ok_q  <= head_q[OFF_W];
				prev_ok_q <= 1'b0;
				steps_q   <= '0;
			end else if (cmd.advance) begin
				cur_ok_q  <= link_rd_q[OFF_W];
				prev_ok_q <= 1'b1;
				steps_q   <= steps_q + 1'b1;
			end
			if (cmd.rd_cur) begin
				split_done_q <= 1'b0;
			end else if (cmd.split_cur_wr) begin
				split_done_q <= 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_tvalid_q <= 1'b0;
		end else if (cmd.res != RES_NONE) begin
			out_tvalid_q <= 1'b1;
		end else if (out_tready) begin
			out_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res != RES_NONE) begin
			status_q <= ST_OK;
			rvalid_q <= 1'b0;
			raddr_q  <= '0;
			cneed_q  <= 1'b0;
			cbytes_q <= '0;
			case (cmd.res)
				RES_FAIL:  status_q <= ST_NOFIT;
				RES_RANGE: status_q <= ST_RANGE;
				RES_KEEP: begin
					rvalid_q <= 1'b1;
					raddr_q  <= addr_q;
				end
				RES_GRANT: begin
					rvalid_q <= 1'b1;
					raddr_q  <= cur_q + OFF_W'(HEADER_BYTES);
					if ((op_q == OP_RESIZE) && has_q) begin
						cneed_q  <= 1'b1;
						cbytes_q <= old_q;
					end
				end
				default: status_q <= ST_OK;
			endcase
		end
	end

	assign out_tvalid = out_tvalid_q;
	assign out_tdata  = {4'b0, cbytes_q, cneed_q, raddr_q, rvalid_q, status_q};

endmodule

// ----- hdl/first_fit_free_list_allocator_top.sv -----
// free/init/range answer from the decode state; a resize that fits answers at the size check
// alloc reads each visited free-list node's header, splits the fitting block if possible
// and unlinks it; resize that moves: size check, alloc walk, then the old block free
// throughput: one item at a time; the header store read of each list node sets the walk
// reset: list head set to offset 0, heap_bytes to 4096, a boot state writes header 0
// before the first item is taken; other header entries are undefined until written
module first_fit_free_list_allocator_top import ffa_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            heap_bytes_we,
	input  logic [HB_W-1:0] heap_bytes_wdata,
	input  logic            s_axis_tvalid,
	output logic            s_axis_tready,
	input  logic [31:0]     s_axis_tdata, // op, has_address, address, request_bytes
	output logic            m_axis_tvalid,
	input  logic            m_axis_tready,
	output logic [31:0] m_axis_tdata // status, result_valid, result_address, copy_needed, copy_bytes
);

	ffa_cmd_t  cmd;
	ffa_stat_t stat;

	// sequencer
	ffa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_tvalid (s_axis_tvalid),
		.in_tready (s_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// stores and registers
	ffa_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.heap_bytes_we    (heap_bytes_we),
		.heap_bytes_wdata (heap_bytes_wdata),
		.in_tdata         (s_axis_tdata),
		.cmd              (cmd),
		.stat             (stat),
		.out_tvalid       (m_axis_tvalid),
		.out_tready       (m_axis_tready),
		.out_tdata        (m_axis_tdata)
	);

endmodule

// ----- hdl/ffa_chk.sv -----
// port-level checker of the first-fit allocator, bound to the top level
// depends on ffa_pkg and first_fit_free_list_allocator_top_macros.svh
`include "first_fit_free_list_allocator_top_macros.svh"

module ffa_chk import ffa_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	input logic            s_axis_tready,
	input logic            m_axis_tvalid,
	input logic            m_axis_tready,
	input logic [31:0]     m_axis_tdata
);

	// a held result keeps its payload
	`FFA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
	// a null result carries a zero address, a failure carries no block
	`FFA_ASSERT_NOW(a_null_addr, m_axis_tvalid && !m_axis_tdata[2], m_axis_tdata[14:3] == 12'd0, "null result with nonzero address")
	`FFA_ASSERT_NOW(a_err_null, m_axis_tvalid && (m_axis_tdata[1:0] != ST_OK), !m_axis_tdata[2] && !m_axis_tdata[15], "error result carries a block")
	// a copy request only comes with a granted block
	`FFA_ASSERT_NOW(a_copy_grant, m_axis_tvalid && m_axis_tdata[15], m_axis_tdata[2] && (m_axis_tdata[1:0] == ST_OK), "copy without a granted block")
	// no new item is taken while a result waits
	`FFA_ASSERT_NOW(a_one_item, m_axis_tvalid, !s_axis_tready, "item taken while a result waits")

endmodule

bind first_fit_free_list_allocator_top ffa_chk u_ffa_chk (.*);
